/* sv/irsg_pkg.sv */
// irsg_pkg: widths, register map, reset values and shared types of the
// interpolated random segment generator. No dependencies.
package irsg_pkg;

    localparam int SEG_W    = 16;              // Q1.15 segment values
    localparam int SR_W     = 18;              // sample rate
    localparam int BFREQ_W  = 24;              // base frequency, Q16.8
    localparam int FMOD_W   = 24;              // frequency offset, Q16.8
    localparam int FREQ_W   = 25;              // clamped frequency
    localparam int BAMP_W   = 16;              // base amplitude, Q4.12
    localparam int AMP_W    = 17;              // base + offset amplitude
    localparam int P1_W     = SEG_W + FREQ_W;  // |diff| * freq
    localparam int MAG_W    = 31;              // ramp offset, up to 2^30
    localparam int RAMP_W   = 32;
    localparam int PROD_W   = AMP_W + RAMP_W;
    localparam int FRAC_SH  = 12;              // Q4.12 * Q1.15 -> Q1.15
    localparam int DEN_SH   = 8;               // Q16.8 frequency fraction
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] REG_BASE_FREQ   = 2'd1;
    localparam logic [1:0] REG_BASE_AMP    = 2'd2;
    localparam logic [1:0] REG_ENABLE      = 2'd3;

    localparam logic [SR_W-1:0]          SAMPLE_RATE_RST = 18'd48000;
    localparam logic [BFREQ_W-1:0]       BASE_FREQ_RST   = 24'd256;
    localparam logic signed [BAMP_W-1:0] BASE_AMP_RST    = 16'sd4096;
    localparam logic                     ENABLE_RST      = 1'b1;

    localparam logic [MAG_W-1:0] MAG_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};

    typedef logic signed [SEG_W-1:0] seg_t;
    typedef logic [MAG_W-1:0]        mag_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* sv/irsg_intf.sv */
// irsg_intf: valid/ready channels for input items and result items.
// Depends on irsg_pkg.
interface irsg_in_if import irsg_pkg::*; #(
    parameter int RANDOM_BITS = 16
);
    logic                     valid;
    logic                     ready;
    logic signed [FMOD_W-1:0] freq_mod;
    logic signed [BAMP_W-1:0] amp_mod;
    logic [RANDOM_BITS-1:0]   random_value;

    modport source (output valid, freq_mod, amp_mod, random_value, input ready);
    modport sink   (input valid, freq_mod, amp_mod, random_value, output ready);
endinterface

interface irsg_out_if import irsg_pkg::*;;
    logic valid;
    logic ready;
    seg_t sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

/* sv/irsg_sdiv.sv */
// irsg_sdiv: bit-serial restoring divider, one dividend bit per cycle,
// quotient saturated at 2^30. Depends on irsg_pkg.
module irsg_sdiv import irsg_pkg::*; #(
    parameter int DW = 57
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DW-1:0]     dividend,
    input  logic [SR_W-1:0]   divisor,
    output div_stat_t         stat,
    output mag_t              quot
);

    localparam int IW = $clog2(DW + 1);

    logic [DW-1:0]   dvd_reg, dvd_next;
    logic [SR_W-1:0] dsr_reg, dsr_next;
    logic [SR_W-1:0] rem_reg, rem_next;
    mag_t            q_reg, q_next;
    logic            sat_reg, sat_next;
    logic [IW-1:0]   iter_reg, iter_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SR_W:0]   trial;
    logic [SR_W:0]   diff;
    logic            qbit;

    // bring down the next dividend bit; no borrow means a quotient one
    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign qbit  = ~diff[SR_W];

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = (divisor == '0) ? SR_W'(1) : divisor;
            rem_next  = '0;
            q_next    = '0;
            sat_next  = 1'b0;
            iter_next = IW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[DW-2:0], 1'b0};
            rem_next  = qbit ? diff[SR_W-1:0] : trial[SR_W-1:0];
            q_next    = {q_reg[MAG_W-2:0], qbit};
            sat_next  = sat_reg | q_reg[MAG_W-1];
            iter_next = iter_reg - IW'(1);
            if (iter_reg == IW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = (sat_reg || q_reg[MAG_W-1]) ? MAG_LIMIT : q_reg;

endmodule

/* sv/interpolated_random_segment_gen.sv */
// Each accepted item passes through the bit-serial count multiply, the
// bit-serial divide by the sample rate and the serial amplitude multiply
// before its result is registered; a disabled item skips all three. A new
// item is taken only after the previous result has gone into the output register.
// Reset (rst_n, async, active low): registers to their defaults, segment
// start/target and sample count to zero, no result pending.
module interpolated_random_segment_gen import irsg_pkg::*; #(
    parameter int COUNT_BITS  = 24,
    parameter int RANDOM_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    irsg_in_if.sink           din,
    irsg_out_if.source        dout,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Numerator |diff| * freq * count, and the same with the Q16.8
    // fraction dropped (dividing by sample_rate*256 = by sample_rate
    // after an 8 bit shift, both floors compose).
    localparam int NW     = P1_W + COUNT_BITS;
    localparam int DW     = NW - DEN_SH;
    localparam int ITER_N = (COUNT_BITS > AMP_W) ? COUNT_BITS : AMP_W;
    localparam int ITER_W = $clog2(ITER_N + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROD   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_RAMP   = 3'd5;
    localparam logic [2:0] S_AMUL   = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    // configuration registers
    logic [SR_W-1:0]          sample_rate_reg;
    logic [BFREQ_W-1:0]       base_freq_reg;
    logic signed [BAMP_W-1:0] base_amp_reg;
    logic                     enable_reg;
    logic                     cfg_wr;

    // segment state
    seg_t                     start_reg, start_next;
    seg_t                     target_reg, target_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;

    // sequencer and datapath
    logic [2:0]               state_reg, state_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic [FREQ_W-1:0]        freq_reg, freq_next;
    logic signed [AMP_W-1:0]  amp_reg, amp_next;
    logic [RANDOM_BITS-1:0]   rv_reg, rv_next;
    logic [SEG_W-1:0]         absd_reg, absd_next;
    logic                     neg_reg, neg_next;
    logic [P1_W-1:0]          p1_reg, p1_next;
    logic [NW-1:0]            acc_reg, acc_next;
    logic [COUNT_BITS-1:0]    csh_reg, csh_next;
    logic signed [RAMP_W-1:0] ramp_reg, ramp_next;
    logic [AMP_W-1:0]         ash_reg, ash_next;
    logic signed [PROD_W-1:0] pacc_reg, pacc_next;
    logic                     out_valid_reg, out_valid_next;
    seg_t                     sample_reg, sample_next;

    // combinational helpers
    logic                     accept;
    logic                     out_free;
    logic signed [FREQ_W:0]   fsum;
    logic signed [SEG_W:0]    sdiff;
    logic [SEG_W:0]           sabs;
    logic [SEG_W-1:0]         rv_scaled;
    seg_t                     new_target;
    logic                     div_start;
    div_stat_t                div_stat;
    mag_t                     div_quot;
    logic signed [RAMP_W-1:0] start_x;
    logic signed [RAMP_W-1:0] mag_x;
    logic                     reached;
    logic signed [PROD_W-1:0] pacc_dbl;
    logic signed [PROD_W-1:0] addend;
    logic signed [PROD_W-1:0] shifted;
    seg_t                     sat_sample;

    // ---------------------------------------------------------------
    // APB register file; pready tied high, write on access phase
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= SAMPLE_RATE_RST;
            base_freq_reg   <= BASE_FREQ_RST;
            base_amp_reg    <= BASE_AMP_RST;
            enable_reg      <= ENABLE_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[ADDR_W-1:2])
                REG_SAMPLE_RATE: sample_rate_reg <= pwdata[SR_W-1:0];
                REG_BASE_FREQ:   base_freq_reg   <= pwdata[BFREQ_W-1:0];
                REG_BASE_AMP:    base_amp_reg    <= pwdata[BAMP_W-1:0];
                REG_ENABLE:      enable_reg      <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_SAMPLE_RATE: prdata = DATA_W'(sample_rate_reg);
            REG_BASE_FREQ:   prdata = DATA_W'(base_freq_reg);
            REG_BASE_AMP:    prdata = DATA_W'(unsigned'(base_amp_reg));
            REG_ENABLE:      prdata = DATA_W'(enable_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Input side: frequency clamped at zero, amplitude sum, |diff|
    // ---------------------------------------------------------------
    assign din.ready = (state_reg == S_IDLE);
    assign accept    = din.valid & din.ready;

    assign fsum  = $signed({2'b00, base_freq_reg})
                 + $signed({{(FREQ_W+1-FMOD_W){din.freq_mod[FMOD_W-1]}}, din.freq_mod});
    assign sdiff = $signed({target_reg[SEG_W-1], target_reg})
                 - $signed({start_reg[SEG_W-1], start_reg});
    assign sabs  = sdiff[SEG_W] ? unsigned'(-sdiff) : unsigned'(sdiff);

    // new target: top 16 of the low RANDOM_BITS bits, offset binary -> Q1.15
    generate
        if (RANDOM_BITS >= SEG_W)
        begin : g_rv_wide
            assign rv_scaled = rv_reg[RANDOM_BITS-1 -: SEG_W];
        end
        else
        begin : g_rv_narrow
            assign rv_scaled = {rv_reg, {(SEG_W-RANDOM_BITS){1'b0}}};
        end
    endgenerate
    assign new_target = {~rv_scaled[SEG_W-1], rv_scaled[SEG_W-2:0]};

    // ---------------------------------------------------------------
    // Divider: floor((|diff|*freq*count >> 8) / sample_rate), sat 2^30
    // ---------------------------------------------------------------
    assign div_start = (state_reg == S_DSTART);

    irsg_sdiv #(
        .DW (DW)
    ) u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg[NW-1:DEN_SH]),
        .divisor  (sample_rate_reg),
        .stat     (div_stat),
        .quot     (div_quot)
    );

    // ramp = start +/- mag; reached when the offset covers |diff|
    assign start_x = RAMP_W'(start_reg);
    assign mag_x   = $signed(RAMP_W'(div_quot));
    assign reached = (div_quot >= MAG_W'(absd_reg));

    // amplitude multiply, MSB first; the sign bit carries negative weight
    assign pacc_dbl = pacc_reg <<< 1;
    assign addend   = ash_reg[AMP_W-1]
                    ? $signed({{(PROD_W-RAMP_W){ramp_reg[RAMP_W-1]}}, ramp_reg})
                    : '0;

    // floor divide by 4096, then clamp to Q1.15
    assign shifted  = pacc_reg >>> FRAC_SH;
    always_comb
    begin
        if (!shifted[PROD_W-1] && (shifted[PROD_W-2:SEG_W-1] != '0))
            sat_sample = {1'b0, {(SEG_W-1){1'b1}}};
        else if (shifted[PROD_W-1] && (shifted[PROD_W-2:SEG_W-1] != '1))
            sat_sample = {1'b1, {(SEG_W-1){1'b0}}};
        else
            sat_sample = shifted[SEG_W-1:0];
    end

    assign out_free = ~out_valid_reg | dout.ready;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        start_next     = start_reg;
        target_next    = target_reg;
        count_next     = count_reg;
        freq_next      = freq_reg;
        amp_next       = amp_reg;
        rv_next        = rv_reg;
        absd_next      = absd_reg;
        neg_next       = neg_reg;
        p1_next        = p1_reg;
        acc_next       = acc_reg;
        csh_next       = csh_reg;
        ramp_next      = ramp_reg;
        ash_next       = ash_reg;
        pacc_next      = pacc_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg & ~dout.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    freq_next = fsum[FREQ_W] ? '0 : unsigned'(fsum[FREQ_W-1:0]);
                    amp_next  = $signed({base_amp_reg[BAMP_W-1], base_amp_reg})
                              + $signed({din.amp_mod[BAMP_W-1], din.amp_mod});
                    rv_next   = din.random_value;
                    absd_next = sabs[SEG_W-1:0];
                    neg_next  = sdiff[SEG_W];
                    if (enable_reg)
                        state_next = S_PROD;
                    else
                    begin
                        // disabled: zero out, state untouched
                        pacc_next  = '0;
                        state_next = S_OUT;
                    end
                end
            end
            S_PROD:
            begin
                p1_next    = P1_W'(absd_reg) * P1_W'(freq_reg);
                acc_next   = '0;
                csh_next   = count_reg;
                iter_next  = ITER_W'(COUNT_BITS);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                acc_next  = {acc_reg[NW-2:0], 1'b0}
                          + (csh_reg[COUNT_BITS-1] ? NW'(p1_reg) : '0);
                csh_next  = {csh_reg[COUNT_BITS-2:0], 1'b0};
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                    state_next = S_DSTART;
            end
            S_DSTART:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_RAMP;
            end
            S_RAMP:
            begin
                ramp_next = neg_reg ? (start_x - mag_x) : (start_x + mag_x);
                if (reached)
                begin
                    start_next  = target_reg;
                    target_next = new_target;
                    count_next  = COUNT_BITS'(1);
                end
                else if (count_reg != '1)
                    count_next = count_reg + COUNT_BITS'(1);
                ash_next   = unsigned'(amp_reg);
                pacc_next  = '0;
                iter_next  = ITER_W'(AMP_W);
                state_next = S_AMUL;
            end
            S_AMUL:
            begin
                if (iter_reg == ITER_W'(AMP_W))
                    pacc_next = pacc_dbl - addend;
                else
                    pacc_next = pacc_dbl + addend;
                ash_next  = {ash_reg[AMP_W-2:0], 1'b0};
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    sample_next    = sat_sample;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            target_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            start_reg     <= start_next;
            target_reg    <= target_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg   <= freq_next;
        amp_reg    <= amp_next;
        rv_reg     <= rv_next;
        absd_reg   <= absd_next;
        neg_reg    <= neg_next;
        p1_reg     <= p1_next;
        acc_reg    <= acc_next;
        csh_reg    <= csh_next;
        ramp_reg   <= ramp_next;
        ash_reg    <= ash_next;
        pacc_reg   <= pacc_next;
        sample_reg <= sample_next;
    end

    assign dout.valid  = out_valid_reg;
    assign dout.sample = sample_reg;

`ifndef SYNTHESIS
    a_off_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !enable_reg) |=> (state_reg == S_OUT))
        else $error("disabled item did not go straight to output");

    a_mag_limit: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (div_quot <= MAG_LIMIT))
        else $error("ramp offset above saturation limit");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RAMP) |=> (count_reg != '0))
        else $error("sample count zero after segment update");

    a_div_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded into output register");
`endif

endmodule

/* test/interpolated_random_segment_gen_test.sv */
// Self-checking testbench for interpolated_random_segment_gen: a bit-accurate
// segment predictor checks every sample item. Random stalls on both channels.
// Depends on irsg_pkg, irsg_intf and the generator RTL.
module interpolated_random_segment_gen_test import irsg_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     COUNT_BITS   = 24;
    localparam int     RANDOM_BITS  = 16;
    localparam int     LIMIT_CYCLES = 1_500_000;  // ~2k items, with a sixfold margin
    localparam int     DRAIN_LIMIT  = 20_000;
    localparam int     HOLD_CYCLES  = 3000;       // long receiver hold-off
    localparam longint RAMP_CAP     = longint'(1) << 30;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    irsg_in_if #(.RANDOM_BITS(RANDOM_BITS)) din_if ();
    irsg_out_if                             dout_if ();

    // Tracks the segment state and register copy, and holds the samples
    // still owed by the block, oldest first.
    class sample_scoreboard;
        logic [SR_W-1:0]          sample_rate;
        logic [BFREQ_W-1:0]       base_freq;
        logic signed [BAMP_W-1:0] base_amp;
        logic                     enable;
        seg_t                     seg_start;
        seg_t                     seg_target;
        logic [COUNT_BITS-1:0]    sample_count;
        seg_t                     expected_samples[$];
        int                       errors;
        int                       checked;

        function new();
            sample_rate  = SAMPLE_RATE_RST;
            base_freq    = BASE_FREQ_RST;
            base_amp     = BASE_AMP_RST;
            enable       = ENABLE_RST;
            seg_start    = '0;
            seg_target   = '0;
            sample_count = '0;
            errors       = 0;
            checked      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_SAMPLE_RATE: sample_rate = value[SR_W-1:0];
                REG_BASE_FREQ:   base_freq   = value[BFREQ_W-1:0];
                REG_BASE_AMP:    base_amp    = value[BAMP_W-1:0];
                REG_ENABLE:      enable      = value[0];
                default: ;
            endcase
        endfunction

        // One sample tick: ramp along the segment, move to a new target once
        // the ramp reaches or overshoots the current one.
        function seg_t predict_sample(logic signed [FMOD_W-1:0] fm,
                                      logic signed [BAMP_W-1:0] am,
                                      logic [RANDOM_BITS-1:0]   rv);
            longint freq, amp, diff, absd, q, den, t, r, m, mag, ramp, prod;
            if (!enable)
                return '0;
            freq = longint'(base_freq) + longint'(fm);
            if (freq < 0)
                freq = 0;
            amp  = longint'(base_amp) + longint'(am);
            diff = longint'(seg_target) - longint'(seg_start);
            absd = (diff < 0) ? -diff : diff;
            q    = freq * longint'(sample_count);
            den  = ((sample_rate == '0) ? longint'(1) : longint'(sample_rate)) * 256;
            t    = q / den;
            r    = q % den;
            if (t >= RAMP_CAP)
                mag = (absd == 0) ? 0 : RAMP_CAP;
            else
            begin
                m   = absd * t + (absd * r) / den;
                mag = (m > RAMP_CAP) ? RAMP_CAP : m;
            end
            ramp = (diff < 0) ? longint'(seg_start) - mag : longint'(seg_start) + mag;
            if (mag >= absd)
            begin
                seg_start    = seg_target;
                seg_target   = seg_t'(rv ^ 16'h8000);
                sample_count = '0;
            end
            if (sample_count != '1)
                sample_count++;
            prod = (amp * ramp) >>> FRAC_SH;
            if (prod > 32767)
                prod = 32767;
            if (prod < -32768)
                prod = -32768;
            return seg_t'(prod);
        endfunction

        function void note_item(logic signed [FMOD_W-1:0] fm, logic signed [BAMP_W-1:0] am,
                                logic [RANDOM_BITS-1:0] rv);
            expected_samples.push_back(predict_sample(fm, am, rv));
        endfunction

        function void check_sample(seg_t got);
            seg_t want;
            if (expected_samples.size() == 0)
            begin
                $error("sample: expected none, got %0d", got);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("sample: expected %0d, got %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    sample_scoreboard sb = new();

    bit steady;          // no idling on either side while set
    bit stall_request;   // asks the result side for a long hold-off
    int cycle_count;
    int settings_used;

    interpolated_random_segment_gen #(
        .COUNT_BITS  (COUNT_BITS),
        .RANDOM_BITS (RANDOM_BITS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_if),
        .dout    (dout_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    // Idles with odds of roughly 37 in a hundred, never during a steady stretch.
    function automatic bit idle_roll();
        return !steady && ($urandom_range(99, 0) < 37);
    endfunction

    // Offers one item, with random gaps beforehand; valid is left high so a
    // following item can go out back to back.
    task automatic send_item(input logic signed [FMOD_W-1:0] fm,
                             input logic signed [BAMP_W-1:0] am,
                             input logic [RANDOM_BITS-1:0]   rv);
        while (idle_roll())
        begin
            din_if.valid <= 1'b0;
            @(posedge clk);
        end
        din_if.valid        <= 1'b1;
        din_if.freq_mod     <= fm;
        din_if.amp_mod      <= am;
        din_if.random_value <= rv;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        sb.note_item(fm, am, rv);
    endtask

    // Mostly small offsets so segments complete; the rest spans the full
    // field, with a share of large negative offsets that clamp the rate.
    task automatic send_random_item();
        logic signed [FMOD_W-1:0] fm;
        logic signed [BAMP_W-1:0] am;
        int unsigned              pick;
        pick = $urandom_range(99, 0);
        if (pick < 65)
            fm = 24'($urandom_range(8191, 0)) - 24'd4096;
        else if (pick < 85)
            fm = 24'($urandom);
        else
            fm = {1'b1, 23'($urandom)};
        if ($urandom_range(99, 0) < 60)
            am = 16'($urandom_range(2047, 0)) - 16'd1024;
        else
            am = 16'($urandom);
        send_item(fm, am, 16'($urandom));
    endtask

    // Setup phase, access phase, then the bus is released.
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    // Sender stops and waits until every owed sample has come back.
    task automatic wait_drained();
        din_if.valid <= 1'b0;
        while (sb.expected_samples.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [DATA_W-1:0] rate, input logic [DATA_W-1:0] freq,
                                  input logic [DATA_W-1:0] amp, input logic en);
        wait_drained();
        write_reg(REG_SAMPLE_RATE, rate);
        write_reg(REG_BASE_FREQ, freq);
        write_reg(REG_BASE_AMP, amp);
        write_reg(REG_ENABLE, DATA_W'(en));
        settings_used++;
    endtask

    // Picks a segment length of 1..64 samples, so targets keep changing.
    task automatic random_settings(input logic en);
        int unsigned rate;
        int unsigned seg_len;
        longint      freq;
        logic [15:0] amp;
        rate    = $urandom_range(192000, 1000);
        seg_len = $urandom_range(64, 1);
        freq    = (longint'(rate) * 256) / seg_len;
        if (freq > longint'(24'hFFFFFF))
            freq = longint'(24'hFFFFFF);
        if ($urandom_range(1, 0))
            amp = 16'($urandom);
        else
            amp = 16'($urandom_range(16383, 0)) - 16'd8192;
        apply_settings(DATA_W'(rate), DATA_W'(freq), {{16{amp[15]}}, amp}, en);
    endtask

    // Result side: checks each accepted sample item, idles at random and
    // serves a long hold-off on request, counted here in cycles.
    initial
    begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        dout_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (dout_if.valid && dout_if.ready)
                sb.check_sample(dout_if.sample);
            if (stall_request)
            begin
                hold_left     = HOLD_CYCLES;
                stall_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                dout_if.ready <= 1'b0;
            end
            else
                dout_if.ready <= !idle_roll();
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d samples outstanding", cycle_count,
               sb.expected_samples.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int i;
        int n;
        int items;
        steady        = 1'b0;
        stall_request = 1'b0;
        settings_used = 0;
        rst_n                <= 1'b0;
        din_if.valid         <= 1'b0;
        din_if.freq_mod      <= '0;
        din_if.amp_mod       <= '0;
        din_if.random_value  <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings. Start and target are both zero, so the first
        // sample takes a new target; a word of 0x8000 gives zero again and
        // keeps start equal to target.
        send_item('0, '0, 16'h8000);
        send_item('0, '0, 16'hFFFF);
        send_item('0, '0, 16'h0000);

        // Four-sample segments at 1 kHz; field extremes.
        apply_settings(32'd1000, 32'd64000, 32'd4096, 1'b1);
        send_item('0, '0, 16'h0000);
        send_item('0, '0, 16'hFFFF);
        send_item(24'sh7FFFFF, '0, 16'h1234);
        send_item(24'sh800000, '0, 16'h8000);   // rate clamps to zero
        send_item('0, 16'sh7FFF, 16'hABCD);
        send_item('0, 16'sh8000, 16'h5555);
        send_item(24'sh800000, 16'sh8000, 16'hFFFF);
        send_item(24'sh7FFFFF, 16'sh7FFF, 16'h0000);
        for (i = 0; i < 4; i++)
            send_item('0, '0, 16'($urandom));

        // Zero sample rate acts as 1 Hz.
        apply_settings(32'd0, 32'd256, 32'd32767, 1'b1);
        for (i = 0; i < 3; i++)
            send_item(24'($urandom_range(511, 0)), '0, 16'($urandom));

        // Register extremes: widest rate word, fastest base rate, most
        // negative base amplitude.
        apply_settings(32'h3FFFF, 32'hFFFFFF, 32'hFFFF8000, 1'b1);
        for (i = 0; i < 3; i++)
            send_random_item();

        // Disabled: zero out, state held for the next enabled phase.
        apply_settings(32'd48000, 32'd256, 32'd4096, 1'b0);
        for (i = 0; i < 3; i++)
            send_random_item();

        // Random phases under varied settings.
        for (p = 0; p < 9; p++)
        begin
            case (p)
                3:       apply_settings(32'd192000, 32'hFFFFFF, 32'd32767, 1'b1);
                4:       apply_settings(32'd1000, 32'd0, 32'hFFFF8000, 1'b1);
                5:       random_settings(1'b0);
                default: random_settings(1'b1);
            endcase
            steady = (p == 1);
            items  = (p == 5) ? 30 : 250;
            for (i = 0; i < items; i++)
            begin
                // Hold results back while items keep being offered, so the
                // block fills and stalls its input.
                if (p == 2 && i == 20)
                    stall_request = 1'b1;
                send_random_item();
            end
            steady = 1'b0;
        end

        din_if.valid <= 1'b0;
        n = 0;
        while (sb.expected_samples.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (2 * COUNT_BITS + 64) @(posedge clk);
        if (sb.expected_samples.size() != 0)
        begin
            $error("sample: %0d expected items never arrived", sb.expected_samples.size());
            sb.errors++;
        end
        $display("Checked %0d samples under %0d register settings, %0d mismatches,",
                 sb.checked, settings_used, sb.errors);
        $display("covering zero rate, clamped rates, disabled output and saturation.");
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
sv/irsg_pkg.sv
sv/irsg_intf.sv
sv/irsg_sdiv.sv
sv/interpolated_random_segment_gen.sv
test/interpolated_random_segment_gen_test.sv
